// ===== rtl/core/loop_detector_ema_hysteresis_core_assert.svh =====
// Assertion macros shared by the loop detector RTL.
`ifndef LOOP_DETECTOR_EMA_HYSTERESIS_CORE_ASSERT_SVH
`define LOOP_DETECTOR_EMA_HYSTERESIS_CORE_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define LDEH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define LDEH_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/ldeh_pkg.sv =====
// Types and constants of the loop detector.
`default_nettype none

package ldeh_pkg;

  localparam int unsigned PeriodW       = 24;
  localparam int unsigned OffsetW       = 16;
  localparam int unsigned AccW          = 32;
  localparam int unsigned CfgIdxW       = 8;
  localparam int unsigned QueueDepth    = 1024;
  localparam int unsigned AverageShift  = 8;
  localparam int unsigned BaselineStart = 17200;

  localparam logic [OffsetW-1:0] EnterOffsetRst = OffsetW'(30);
  localparam logic [OffsetW-1:0] LeaveOffsetRst = OffsetW'(15);

  localparam logic [CfgIdxW-1:0] CfgEnter = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgLeave = CfgIdxW'(1);

  typedef enum logic {
    OP_MEASURE = 1'b0,
    OP_READ    = 1'b1
  } ldeh_op_e;

  typedef struct packed {
    logic push;
    logic pop;
  } ldeh_qreq_t;

endpackage

`default_nettype wire

// ===== rtl/core/ldeh_if.sv =====
// Channel interfaces of the loop detector: input, result and configuration.
`default_nettype none

interface ldeh_in_if;
  import ldeh_pkg::*;
  logic                 valid;
  logic                 ready;
  ldeh_op_e             op;
  logic [PeriodW-1:0]   period;
  modport source (output valid, output op, output period, input ready);
  modport sink   (input valid, input op, input period, output ready);
endinterface

interface ldeh_out_if;
  import ldeh_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 vehicle_present;
  logic [PeriodW-1:0]   average;
  logic [PeriodW-1:0]   read_value;
  modport source (output valid, output vehicle_present, output average, output read_value,
                  input ready);
  modport sink   (input valid, input vehicle_present, input average, input read_value,
                  output ready);
endinterface

interface ldeh_cfg_if;
  import ldeh_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CfgIdxW-1:0]   index;
  logic [OffsetW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/loop_detector_ema_hysteresis_core.sv =====
// Top level of the inductive-loop vehicle detector.
//
//  Channel | Dir | Transfer when        | Payload
//  --------+-----+----------------------+-------------------------------------
//  in_i    | in  | valid & ready        | op, period
//  out_o   | out | valid & ready        | vehicle_present, average, read_value
//  cfg_i   | in  | valid (ready tied 1) | index, data (enter/leave offset)
//
// One item per cycle sustained while the output is not stalled: accept updates
// the accumulator and issues the queue memory access, then the middle stage
// compares against the thresholds and loads the output register.
// A stalled output holds the middle stage, which then holds the input.
// Reset clears pointers and flag and presets the accumulator to the baseline at
// once; slot zero reads as zero until the queue wraps, so no clearing pass is needed.
`default_nettype none
`include "loop_detector_ema_hysteresis_core_assert.svh"

module loop_detector_ema_hysteresis_core #(
  parameter int unsigned QUEUE_DEPTH   = ldeh_pkg::QueueDepth,
  parameter int unsigned AVERAGE_SHIFT = ldeh_pkg::AverageShift
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  ldeh_in_if.sink    in_i,
  ldeh_out_if.source out_o,
  ldeh_cfg_if.sink   cfg_i
);
  import ldeh_pkg::*;

  localparam logic [AccW-1:0] AccRst = AccW'(BaselineStart) << AVERAGE_SHIFT;

  // Configuration registers
  logic [OffsetW-1:0] enter_q, leave_q;

  // Accumulator and presence flag
  logic [AccW-1:0]    acc_q, acc_d;
  logic [AccW:0]      acc_sum;
  logic               presence_q, presence_d;

  // Middle stage
  logic               s1_valid_q;
  ldeh_op_e           s1_op_q;
  logic [PeriodW-1:0] s1_period_q;
  logic               s1_adv;

  // Output register
  logic               out_valid_q;
  logic               out_pres_q;
  logic [PeriodW-1:0] out_avg_q, out_read_q;

  logic               in_acc;
  ldeh_qreq_t         qreq;
  logic [PeriodW-1:0] q_rdata;
  logic               q_rzero;

  logic [AccW-1:0]    avg_full;
  logic [PeriodW-1:0] avg;
  logic [PeriodW:0]   set_sum, clr_sum;
  logic               set_hit, clr_hit;

  // Handshake: the middle stage drains whenever the output register frees up.
  assign s1_adv     = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enter_q <= EnterOffsetRst;
      leave_q <= LeaveOffsetRst;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CfgEnter) begin
        enter_q <= cfg_i.data;
      end else if (cfg_i.index == CfgLeave) begin
        leave_q <= cfg_i.data;
      end
    end
  end

  // Accumulator update on accept: acc - (acc >> shift) + period, saturate.
  assign acc_sum = {1'b0, acc_q} - {1'b0, (acc_q >> AVERAGE_SHIFT)}
                 + (AccW + 1)'(in_i.period);

  always_comb begin
    acc_d = acc_q;
    if (in_acc && (in_i.op == OP_MEASURE)) begin
      acc_d = acc_sum[AccW] ? '1 : acc_sum[AccW-1:0];
    end
  end

  // Queue: push on a measurement, pop on a read.
  assign qreq.push = in_acc && (in_i.op == OP_MEASURE);
  assign qreq.pop  = in_acc && (in_i.op == OP_READ);

  ldeh_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (qreq),
    .wdata_i (in_i.period),
    .rdata_o (q_rdata),
    .rzero_o (q_rzero)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= AccRst;
      s1_valid_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q     <= in_i.op;
      s1_period_q <= in_i.period;
    end
  end

  // Average seen by the middle-stage item; acc_q already holds its update.
  assign avg_full = acc_q >> AVERAGE_SHIFT;
  assign avg      = (|avg_full[AccW-1:PeriodW]) ? '1 : avg_full[PeriodW-1:0];

  // period < avg - enter  <=>  period + enter < avg; a negative threshold sets.
  assign set_sum = {1'b0, s1_period_q} + (PeriodW + 1)'(enter_q);
  assign clr_sum = {1'b0, s1_period_q} + (PeriodW + 1)'(leave_q);
  assign set_hit = (avg < PeriodW'(enter_q)) || (set_sum < {1'b0, avg});
  assign clr_hit = (avg >= PeriodW'(leave_q)) && (clr_sum > {1'b0, avg});

  always_comb begin
    presence_d = presence_q;
    if (s1_valid_q && s1_adv && (s1_op_q == OP_MEASURE)) begin
      if (set_hit) begin
        presence_d = 1'b1;
      end else if (clr_hit) begin
        presence_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presence_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      presence_q <= presence_d;
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Load the result; a read of a never-written slot returns zero.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      out_pres_q <= presence_d;
      out_avg_q  <= avg;
      out_read_q <= ((s1_op_q == OP_READ) && !q_rzero) ? q_rdata : '0;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.vehicle_present = out_pres_q;
  assign out_o.average         = out_avg_q;
  assign out_o.read_value      = out_read_q;

  `LDEH_ASSERT(a_meas_to_s1, qreq.push |=> s1_valid_q && s1_op_q == OP_MEASURE, "item lost")
  `LDEH_ASSERT(a_acc_stall, (s1_valid_q && !s1_adv) |=> $stable(acc_q), "acc moved on stall")
  `LDEH_ASSERT(a_ready_when_empty, !out_valid_q |-> in_i.ready, "input blocked when empty")

endmodule

`default_nettype wire

// ===== rtl/core/ldeh_queue.sv =====
// Period queue: ring buffer memory with write and read pointers.
`default_nettype none
`include "loop_detector_ema_hysteresis_core_assert.svh"

module ldeh_queue #(
  parameter int unsigned QUEUE_DEPTH = ldeh_pkg::QueueDepth
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  ldeh_pkg::ldeh_qreq_t           req_i,
  input  wire  [ldeh_pkg::PeriodW-1:0]   wdata_i,
  output logic [ldeh_pkg::PeriodW-1:0]   rdata_o,
  output logic                           rzero_o
);
  import ldeh_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(QUEUE_DEPTH - 1);

  logic [PeriodW-1:0] mem_q [QUEUE_DEPTH];

  logic [PtrW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic               wrapped_q, wrapped_d;
  logic [PtrW-1:0]    wp_nxt, rp_nxt;
  logic [PeriodW-1:0] rdata_q;
  logic               rzero_q;

  // Write pointer moves first, then the slot is written.
  assign wp_nxt = (wp_q == LastSlot) ? '0 : wp_q + PtrW'(1);
  // Read pointer stays put on an empty queue.
  assign rp_nxt = (rp_q == wp_q) ? rp_q : ((rp_q == LastSlot) ? '0 : rp_q + PtrW'(1));

  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    wrapped_d = wrapped_q;
    if (req_i.push) begin
      wp_d = wp_nxt;
      if (wp_nxt == '0) begin
        wrapped_d = 1'b1;
      end
    end
    if (req_i.pop) begin
      rp_d = rp_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      rp_q      <= '0;
      wrapped_q <= 1'b0;
      rzero_q   <= 1'b1;
    end else begin
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      wrapped_q <= wrapped_d;
      // Slot zero is the only one a read can reach before it was written.
      if (req_i.pop) begin
        rzero_q <= (rp_nxt == '0) && !wrapped_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem_q[wp_nxt] <= wdata_i;
    end
    if (req_i.pop) begin
      rdata_q <= mem_q[rp_nxt];
    end
  end

  assign rdata_o = rdata_q;
  assign rzero_o = rzero_q;

  `LDEH_ASSERT(a_rp_trails_wp, !wrapped_q |-> (rp_q <= wp_q), "read passed write")
  `LDEH_ASSERT(a_empty_hold, (req_i.pop && rp_q == wp_q) |=> $stable(rp_q), "empty read moved")
  `LDEH_ASSERT_NEVER(a_no_push_pop, req_i.push && req_i.pop, "push and pop together")

endmodule

`default_nettype wire
